/* design/ast_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants of the source tokenizer
// Character codes, lexer modes and the per-character result plan that
// travels from the classifying front end to the output sequencer.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int MAX_RESULTS = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] DEPTH_MAX = 8'hFF;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_BLOCK   = 2'd1;
    localparam logic [1:0] MODE_COMMENT = 2'd2;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // One result: kind in bit 8, character in bits 7:0.
    typedef logic [8:0] result_t;

    typedef struct packed {
        logic [2:0]                        cnt;
        logic [MAX_RESULTS-1:0][8:0]       items;
    } plan_t;

endpackage
`default_nettype wire

/* design/ast_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ast_front: character classifier and lexer state
// Accepts one character per cycle while the queue has room, updates the lexer
// state and builds the ordered list of results that the character causes.
// ----------------------------------------------------------------------------
module ast_front
    import ast_pkg::*;
#(
    parameter int MAX_TOKEN = 255
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_char,
    input  wire logic       in_last,
    output logic            push,
    output plan_t           push_plan,
    input  wire logic       queue_full
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN);

    typedef struct packed {
        logic [7:0] len;
        plan_t      plan;
    } acc_t;

    logic [1:0] mode_reg, mode_next;
    logic       paren_reg, paren_next;
    logic [7:0] depth_reg, depth_next;
    logic [7:0] len_reg, len_next;
    logic       slash_reg, slash_next;
    logic       esc_reg, esc_next;
    plan_t      plan;
    logic       accept;

    function automatic acc_t emit_op(acc_t a, logic [7:0] c);
        acc_t r;
        r = a;
        r.plan.items[r.plan.cnt] = {KIND_CHAR, c};
        r.plan.cnt = r.plan.cnt + 3'd1;
        r.len = r.len + 8'd1;
        if (r.len >= MAX_LEN)
        begin
            r.plan.items[r.plan.cnt] = {KIND_END, 8'h00};
            r.plan.cnt = r.plan.cnt + 3'd1;
            r.len = 8'd0;
        end
        return r;
    endfunction

    function automatic acc_t end_op(acc_t a);
        acc_t r;
        r = a;
        if (r.len != 8'd0)
        begin
            r.plan.items[r.plan.cnt] = {KIND_END, 8'h00};
            r.plan.cnt = r.plan.cnt + 3'd1;
            r.len = 8'd0;
        end
        return r;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic pre_slash;
        logic pre_end;
        logic main_emit;
        logic post_end;
        logic is_space;
        logic normal;
        acc_t acc;

        mode_next  = mode_reg;
        paren_next = paren_reg;
        depth_next = depth_reg;
        slash_next = slash_reg;
        esc_next   = esc_reg;
        pre_slash  = 1'b0;
        pre_end    = 1'b0;
        main_emit  = 1'b0;
        post_end   = 1'b0;
        normal     = 1'b0;
        is_space   = (in_char == CH_NL) || (in_char == CH_CR) || (in_char == CH_TAB) ||
                     (in_char == CH_VT) || (in_char == CH_FF) || (in_char == CH_SPACE);

        case (mode_reg)
            MODE_BLOCK:
            begin
                if (paren_reg)
                begin
                    main_emit = 1'b1;
                    if (in_char == CH_LPAREN)
                    begin
                        if (depth_reg < DEPTH_MAX)
                            depth_next = depth_reg + 8'd1;
                    end
                    else if (in_char == CH_RPAREN)
                    begin
                        if (depth_reg > 8'd0)
                            depth_next = depth_reg - 8'd1;
                        if (depth_next == 8'd0)
                        begin
                            post_end  = 1'b1;
                            mode_next = MODE_NORMAL;
                        end
                    end
                end
                else if (esc_reg)
                begin
                    esc_next  = 1'b0;
                    main_emit = 1'b1;
                end
                else if (in_char == CH_BSLASH)
                begin
                    main_emit = 1'b1;
                    esc_next  = 1'b1;
                end
                else if (in_char == CH_QUOTE)
                begin
                    main_emit = 1'b1;
                    post_end  = 1'b1;
                    mode_next = MODE_NORMAL;
                end
                else
                begin
                    main_emit = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (in_char == CH_NL)
                begin
                    mode_next = MODE_NORMAL;
                    post_end  = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                if (slash_reg)
                begin
                    slash_next = 1'b0;
                    if (in_char == CH_SLASH)
                        mode_next = MODE_COMMENT;
                    else
                    begin
                        pre_slash = 1'b1;
                        normal    = 1'b1;
                    end
                end
                else
                begin
                    normal = 1'b1;
                end
            end
        endcase

        if (normal)
        begin
            if (esc_reg)
            begin
                esc_next  = 1'b0;
                main_emit = 1'b1;
            end
            else if (is_space)
            begin
                pre_end = 1'b1;
            end
            else if (in_char == CH_BSLASH)
            begin
                main_emit = 1'b1;
                esc_next  = 1'b1;
            end
            else if (in_char == CH_QUOTE)
            begin
                main_emit  = 1'b1;
                mode_next  = MODE_BLOCK;
                paren_next = 1'b0;
                depth_next = 8'd0;
            end
            else if (in_char == CH_LPAREN)
            begin
                main_emit  = 1'b1;
                mode_next  = MODE_BLOCK;
                paren_next = 1'b1;
                depth_next = 8'd1;
            end
            else if ((in_char == CH_LBRACK) || (in_char == CH_RBRACK))
            begin
                pre_end   = 1'b1;
                main_emit = 1'b1;
                post_end  = 1'b1;
            end
            else if (in_char == CH_SLASH)
            begin
                slash_next = 1'b1;
            end
            else
            begin
                main_emit = 1'b1;
            end
        end

        acc.len  = len_reg;
        acc.plan = '0;
        if (pre_slash)
            acc = emit_op(acc, CH_SLASH);
        if (pre_end)
            acc = end_op(acc);
        if (main_emit)
            acc = emit_op(acc, in_char);
        if (post_end)
            acc = end_op(acc);
        if (in_last)
        begin
            if (slash_next)
                acc = emit_op(acc, CH_SLASH);
            acc = end_op(acc);
            mode_next  = MODE_NORMAL;
            paren_next = 1'b0;
            depth_next = 8'd0;
            slash_next = 1'b0;
            esc_next   = 1'b0;
        end
        len_next = acc.len;
        plan     = acc.plan;
    end

    assign push      = accept && (plan.cnt != 3'd0);
    assign push_plan = plan;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            paren_reg <= 1'b0;
            depth_reg <= 8'd0;
            len_reg   <= 8'd0;
            slash_reg <= 1'b0;
            esc_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            paren_reg <= paren_next;
            depth_reg <= depth_next;
            len_reg   <= len_next;
            slash_reg <= slash_next;
            esc_reg   <= esc_next;
        end
    end

    // A token is cut when it reaches the maximum length, so the open length stays below it.
    assert property (@(posedge clk) disable iff (!rst_n) len_reg < MAX_LEN)
        else $error("open token length reached the maximum");

    // A held slash and a pending escape never coexist, and neither lives in a comment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_COMMENT) |-> (!slash_reg && !esc_reg))
        else $error("slash or escape pending inside a comment");

    // A transfer marked last leaves the lexer back in its idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (mode_reg == MODE_NORMAL && len_reg == 8'd0 && !slash_reg))
        else $error("lexer not idle after the final character");

endmodule
`default_nettype wire

/* design/ast_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ast_queue: result plan queue
// Small first-in first-out buffer of result plans between the classifier
// and the output sequencer.
// ----------------------------------------------------------------------------
module ast_queue
    import ast_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire plan_t push_plan,
    input  wire logic  pop,
    output plan_t      head_plan,
    output logic       empty,
    output logic       full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    plan_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign empty     = (count_reg == CNT_W'(0));
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_plan = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_plan;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("plan written into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("plan taken from an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond its depth");

endmodule
`default_nettype wire

/* design/ast_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ast_back: output sequencer
// Walks the results of the plan at the head of the queue one per cycle, while
// the receiver is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module ast_back
    import ast_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire plan_t      head_plan,
    input  wire logic       empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            out_kind,
    output logic [7:0]      out_char,
    output logic            out_last
);

    logic       valid_reg;
    logic       kind_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic [2:0] idx_reg;
    logic       load;
    logic       take;
    logic       final_item;
    result_t    cur_item;

    assign load       = !valid_reg || out_ready;
    assign take       = load && !empty;
    assign cur_item   = head_plan.items[idx_reg];
    assign final_item = (idx_reg == (head_plan.cnt - 3'd1));
    assign pop        = take && final_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else if (load)
        begin
            valid_reg <= !empty;
            if (take)
            begin
                if (final_item)
                    idx_reg <= 3'd0;
                else
                    idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= cur_item[8];
            char_reg <= cur_item[7:0];
            last_reg <= final_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

/* design/assembler_source_tokenizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// assembler_source_tokenizer: whitespace delimited source tokenizer
// Splits a stream of source characters into tokens of characters with
// end-of-token markers.
// ----------------------------------------------------------------------------
// Usage:
// Source characters enter on the s_axis channel, one per transfer; s_axis_tlast
// marks the final character of the text and flushes the open token.
// Results leave on the m_axis channel: tuser is 0 for a token character in
// tdata and 1 for an end-of-token marker (tdata zero). m_axis_tlast is set on
// the last result caused by one input character; a character that causes no
// result produces no transfer.
// The classifier takes one character per cycle while the queue is not full and
// puts its results (one to four) into a four-entry queue; the sequencer sends
// one result per cycle while the receiver is ready. The first result of a
// character passes through a queue entry and then the output register before
// it reaches m_axis. Sustained throughput is one result per cycle while the
// receiver is ready, set by the single-result output stage.
// When the receiver stalls, the output register holds and the queue keeps
// the results of up to four characters before s_axis_tready falls.
// Reset clears the lexer state, the queue and the output stage.
// ----------------------------------------------------------------------------
module assembler_source_tokenizer
    import ast_pkg::*;
#(
    parameter int MAX_TOKEN = 255
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // ch
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // out_char
    output logic            m_axis_tuser,   // kind
    output logic            m_axis_tlast
);

    logic  push;
    plan_t push_plan;
    logic  pop;
    plan_t head_plan;
    logic  empty;
    logic  full;

    ast_front #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_char    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .push       (push),
        .push_plan  (push_plan),
        .queue_full (full)
    );

    ast_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_plan (push_plan),
        .pop       (pop),
        .head_plan (head_plan),
        .empty     (empty),
        .full      (full)
    );

    ast_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_plan (head_plan),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire
